### sv/tpp_pkg.sv
// ----------------------------------------------------------------------------
// Timed pattern player package
// Shared types and codes for the pattern player and its parts.
// ----------------------------------------------------------------------------
package tpp_pkg;

	// Item action codes.
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2,
		ACT_WRITE = 2'd3
	} tpp_action_t;

	// Configuration register indexes.
	localparam logic REG_STEP_COUNT = 1'b0;
	localparam logic REG_PLAY_COUNT = 1'b1;

	// One table entry: duration in the upper half, level in the lower half.
	typedef struct packed {
		logic [15:0] duration;
		logic [15:0] level;
	} tpp_step_t;

	// Result of one item as it leaves the sequencer.
	typedef struct packed {
		logic        from_mem;
		logic [15:0] level;
		logic        written;
		logic        playing;
		logic        finished;
	} tpp_result_t;

endpackage

### sv/timed_pattern_player.sv
// ----------------------------------------------------------------------------
// Timed pattern player
// Plays a stored table of (level, duration) steps on one output, driven by
// tick, start, stop and table write beats.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Content
//  in        sink       in_valid / in_stall    action, step_index, level, duration
//  out       source     out_valid / out_stall  level, level_written, playing, finished
//  cfg       sink       cfg_write              cfg_index, cfg_data
//
//  One beat is accepted every cycle while in_stall is low; its result goes from
//  the first stage to the output register (table read, then result resolve).
//  The step table memory has one read port, used by the beat that enters a step.
//  Reset clears the play state; the table holds no defined value until written.
//  A stalled output holds one result and one more beat in flight before in_stall.
// ----------------------------------------------------------------------------
module timed_pattern_player #(
	parameter int MAX_STEPS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [4:0]        step_index,
	input  logic [15:0]       step_level,
	input  logic [15:0]       step_duration,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       level,
	output logic              level_written,
	output logic              playing,
	output logic              finished
);

	localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

	logic                  accept;
	logic                  out_free;
	logic                  s1_move;
	logic [5:0]            step_count_q;
	logic signed [7:0]     play_count_q;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	tpp_pkg::tpp_step_t    wr_data;
	tpp_pkg::tpp_step_t    rd_data;
	tpp_pkg::tpp_result_t  result;
	logic                  s1_v_s1;
	tpp_pkg::tpp_result_t  res_s1;
	logic                  out_v_q;
	logic [15:0]           level_q;
	logic                  written_q;
	logic                  playing_q;
	logic                  finished_q;

	// Handshake: the output register parts the two sides.
	assign out_free = !out_v_q || !out_stall;
	assign s1_move  = s1_v_s1 && out_free;
	assign in_stall = s1_v_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= 6'd1;
			play_count_q <= 8'sd1;
		end else if (cfg_write) begin
			case (cfg_index)
				tpp_pkg::REG_STEP_COUNT: step_count_q <= cfg_data[5:0];
				tpp_pkg::REG_PLAY_COUNT: play_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tpp_sequencer #(
		.MAX_STEPS (MAX_STEPS),
		.AW        (AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.action        (action),
		.step_index    (step_index),
		.step_level    (step_level),
		.step_duration (step_duration),
		.step_count    (step_count_q),
		.play_count    (play_count_q),
		.rd_data       (rd_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.result        (result)
	);

	tpp_step_mem #(
		.DEPTH (MAX_STEPS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// First stage: result waiting for the table read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
		end else begin
			s1_v_s1 <= accept || in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= result;
		end
	end

	// Output register: resolve the level from the table where a step was entered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= s1_move || (out_v_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			level_q    <= res_s1.from_mem ? rd_data.level : res_s1.level;
			written_q  <= res_s1.written;
			playing_q  <= res_s1.playing;
			finished_q <= res_s1.finished;
		end
	end

	assign out_valid     = out_v_q;
	assign level         = level_q;
	assign level_written = written_q;
	assign playing       = playing_q;
	assign finished      = finished_q;

`ifndef ASSERT_OFF
	// Input is held back only while both stages are full and the output stalls.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_v_q && out_stall && s1_v_s1))
		else $error("in_stall raised without a full, stalled pipeline");

	// A finishing beat drives level zero and leaves the player idle.
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && finished_q) |-> (!playing_q && written_q && level_q == 16'd0))
		else $error("finished result with a running player or non-zero level");

	// A beat that entered a step always reports a new level while playing.
	a_load_written: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_s1 && res_s1.from_mem) |-> (res_s1.written && res_s1.playing))
		else $error("table read issued by a beat that drives no level");
`endif

endmodule

### sv/tpp_step_mem.sv
// ----------------------------------------------------------------------------
// Step table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tpp_step_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  tpp_pkg::tpp_step_t wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output tpp_pkg::tpp_step_t rd_data
);

	tpp_pkg::tpp_step_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/tpp_sequencer.sv
// ----------------------------------------------------------------------------
// Pattern sequencer
// Holds the play state, issues table reads and writes, and forms the
// result of each beat. A step entered by a beat has its level and duration
// delivered by the memory in the next cycle; until committed, they are
// forwarded from the read data.
// ----------------------------------------------------------------------------
module tpp_sequencer #(
	parameter int MAX_STEPS = 32,
	parameter int AW        = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            action,
	input  logic [4:0]            step_index,
	input  logic [15:0]           step_level,
	input  logic [15:0]           step_duration,
	input  logic [5:0]            step_count,
	input  logic signed [7:0]     play_count,
	input  tpp_pkg::tpp_step_t    rd_data,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output tpp_pkg::tpp_step_t    wr_data,
	output tpp_pkg::tpp_result_t  result
);

	logic [5:0]        pos_q, pos_d;
	logic [5:0]        used_q, used_d;
	logic signed [7:0] plays_q, plays_d;
	logic [15:0]       ticks_q, ticks_d;
	logic [15:0]       level_q, level_d;
	logic              run_q, run_d;
	logic              pend_q, pend_d;
	logic [15:0]       eff_level;
	logic [15:0]       eff_ticks;
	logic [6:0]        pos_inc;
	logic              load;
	logic [5:0]        load_pos;

	// Forward a step just read from the table until it is committed.
	always_comb begin
		eff_level = pend_q ? rd_data.level : level_q;
		if (pend_q) begin
			eff_ticks = (rd_data.duration == 16'd0) ? 16'd1 : rd_data.duration;
		end else begin
			eff_ticks = ticks_q;
		end
	end

	assign pos_inc = {1'b0, pos_q} + 7'd1;
	assign wr_addr = AW'(step_index);
	assign wr_data = '{duration: step_duration, level: step_level};

	// Next state and result of the beat being accepted.
	always_comb begin
		pos_d    = pos_q;
		used_d   = used_q;
		plays_d  = plays_q;
		ticks_d  = eff_ticks;
		level_d  = eff_level;
		run_d    = run_q;
		load     = 1'b0;
		load_pos = '0;
		wr_en    = 1'b0;
		result   = '0;
		if (accept) begin
			case (tpp_pkg::tpp_action_t'(action))
				tpp_pkg::ACT_TICK: begin
					if (run_q) begin
						if (eff_ticks > 16'd1) begin
							ticks_d = eff_ticks - 16'd1;
						end else if (pos_inc >= {1'b0, used_q}) begin
							// End of the table: wrap, or finish the last play.
							if (plays_q < 0) begin
								pos_d = '0;
								load  = 1'b1;
							end else if (plays_q <= 8'sd1) begin
								level_d         = '0;
								plays_d         = '0;
								ticks_d         = '0;
								run_d           = 1'b0;
								result.written  = 1'b1;
								result.finished = 1'b1;
							end else begin
								plays_d = plays_q - 8'sd1;
								pos_d   = '0;
								load    = 1'b1;
							end
						end else begin
							pos_d    = pos_inc[5:0];
							load_pos = pos_inc[5:0];
							load     = 1'b1;
						end
					end
				end
				tpp_pkg::ACT_START: begin
					if (step_count != 6'd0) begin
						if (step_count > MAX_STEPS) begin
							used_d = 6'(MAX_STEPS);
						end else begin
							used_d = step_count;
						end
						pos_d   = '0;
						plays_d = (play_count == 8'sd0) ? 8'sd1 : play_count;
						run_d   = 1'b1;
						load    = 1'b1;
					end
				end
				tpp_pkg::ACT_STOP: begin
					run_d          = 1'b0;
					ticks_d        = '0;
					plays_d        = '0;
					level_d        = '0;
					result.written = 1'b1;
				end
				tpp_pkg::ACT_WRITE: begin
					wr_en = step_index < MAX_STEPS;
				end
				default: begin
				end
			endcase
			if (load) begin
				result.from_mem = 1'b1;
				result.written  = 1'b1;
			end
			result.level   = level_d;
			result.playing = run_d;
		end
	end

	assign pend_d  = load;
	assign rd_en   = load;
	assign rd_addr = AW'(load_pos);

	// Play state registers; a pending step is committed every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			used_q  <= '0;
			plays_q <= '0;
			ticks_q <= '0;
			level_q <= '0;
			run_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			pos_q   <= pos_d;
			used_q  <= used_d;
			plays_q <= plays_d;
			ticks_q <= ticks_d;
			level_q <= level_d;
			run_q   <= run_d;
			pend_q  <= pend_d;
		end
	end

endmodule

### sim/tpp_checker.sv
// ----------------------------------------------------------------------------
// Pattern player checker
// Watches the configuration port and both beat channels of the pattern
// player, keeps its own copy of the step table and play state, works out the
// result of every accepted beat and compares each result beat with the oldest
// one still due.
// ----------------------------------------------------------------------------
module tpp_checker #(
	parameter int MAX_STEPS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [4:0]  step_index,
	input  logic [15:0] step_level,
	input  logic [15:0] step_duration,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] level,
	input  logic        level_written,
	input  logic        playing,
	input  logic        finished,
	output int          mismatches,
	output int          pending
);

	// One result beat as the player should present it.
	typedef struct packed {
		logic [15:0] level;
		logic        written;
		logic        playing;
		logic        finished;
	} player_out_t;

	// Own copy of the table, the play state and the two registers.
	tpp_pkg::tpp_step_t steps [MAX_STEPS];
	int unsigned position;
	int unsigned used_steps;
	int          plays_to_go;
	logic [15:0] ticks_left;
	logic [15:0] cur_level;
	logic        running;
	logic [5:0]  step_count_reg;
	logic [7:0]  play_count_reg;

	// Results of accepted beats that have not yet left the player.
	player_out_t due_outputs [$];

	// Prints one line for a mismatch and counts it.
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
	endtask

	// Enters a table step: drives its level and loads its countdown.
	task automatic load_step(input int unsigned idx);
		tpp_pkg::tpp_step_t s;
		s = steps[idx];
		cur_level = s.level;
		ticks_left = (s.duration == 16'd0) ? 16'd1 : s.duration;
	endtask

	// Applies one beat to the play state and gives the result it causes.
	task automatic step_player(input tpp_pkg::tpp_action_t act, input logic [4:0] idx,
			input logic [15:0] lev, input logic [15:0] dur, output player_out_t r);
		logic              wrote;
		logic              done;
		logic signed [7:0] pc;
		wrote = 1'b0;
		done = 1'b0;
		case (act)
			tpp_pkg::ACT_TICK: begin
				if (running) begin
					if (ticks_left > 16'd1) begin
						ticks_left--;
					end else begin
						position++;
						wrote = 1'b1;
						if (position >= used_steps && plays_to_go >= 0 &&
								plays_to_go <= 1) begin
							// The last play has run out: drive zero and stop.
							cur_level = 16'd0;
							plays_to_go = 0;
							ticks_left = 16'd0;
							running = 1'b0;
							done = 1'b1;
						end else begin
							if (position >= used_steps) begin
								if (plays_to_go > 1) begin
									plays_to_go--;
								end
								position = 0;
							end
							load_step(position);
						end
					end
				end
			end
			tpp_pkg::ACT_START: begin
				// A start with no steps to play changes nothing.
				if (step_count_reg != 6'd0) begin
					pc = $signed(play_count_reg);
					used_steps = (step_count_reg > MAX_STEPS) ? MAX_STEPS : step_count_reg;
					position = 0;
					plays_to_go = (pc == 0) ? 1 : pc;
					running = 1'b1;
					load_step(0);
					wrote = 1'b1;
				end
			end
			tpp_pkg::ACT_STOP: begin
				running = 1'b0;
				ticks_left = 16'd0;
				plays_to_go = 0;
				cur_level = 16'd0;
				wrote = 1'b1;
			end
			tpp_pkg::ACT_WRITE: begin
				if (idx < MAX_STEPS) begin
					steps[idx] = {dur, lev};
				end
			end
			default: begin
			end
		endcase
		r = '{level: cur_level, written: wrote, playing: running, finished: done};
	endtask

	// Register writes, beat prediction and result comparison.
	always @(posedge clk or negedge arst_n) begin : watch
		player_out_t want;
		player_out_t got;
		if (!arst_n) begin
			position = 0;
			used_steps = 0;
			plays_to_go = 0;
			ticks_left = 16'd0;
			cur_level = 16'd0;
			running = 1'b0;
			step_count_reg = 6'd1;
			play_count_reg = 8'd1;
			mismatches = 0;
			due_outputs.delete();
			pending <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == tpp_pkg::REG_STEP_COUNT) begin
					step_count_reg = cfg_data[5:0];
				end else begin
					play_count_reg = cfg_data;
				end
			end
			if (in_valid && !in_stall) begin
				step_player(tpp_pkg::tpp_action_t'(action), step_index, step_level,
					step_duration, want);
				due_outputs.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = '{level: level, written: level_written, playing: playing,
					finished: finished};
				if (due_outputs.size() == 0) begin
					report_mismatch("result beat with nothing due", 32'(got), 32'd0);
				end else begin
					want = due_outputs.pop_front();
					if (got.level !== want.level) begin
						report_mismatch("level", 32'(got.level), 32'(want.level));
					end
					if (got.written !== want.written) begin
						report_mismatch("level_written", 32'(got.written),
							32'(want.written));
					end
					if (got.playing !== want.playing) begin
						report_mismatch("playing", 32'(got.playing), 32'(want.playing));
					end
					if (got.finished !== want.finished) begin
						report_mismatch("finished", 32'(got.finished),
							32'(want.finished));
					end
				end
			end
			pending <= due_outputs.size();
		end
	end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// Pattern player testbench
// Drives tick, start, stop and table write beats into the pattern player under
// a range of step and play counts, with random gaps on the input and random
// stalls on the output. The checker beside the player predicts and compares;
// this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

	localparam int ITEM_TARGET = 1600;
	localparam int CALM_ITEMS = 150;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = 2'd0;
	logic [4:0]  step_index = 5'd0;
	logic [15:0] step_level = 16'd0;
	logic [15:0] step_duration = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] level;
	logic        level_written;
	logic        playing;
	logic        finished;
	int          mismatches;
	int          pending;

	int          beats_sent = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;
	bit          gappy = 1'b1;
	bit [31:0]   table_filled = '0;
	logic [5:0]  cur_step_count = 6'd1;

	timed_pattern_player #(.MAX_STEPS(32)) dut (.*);

	tpp_checker #(.MAX_STEPS(32)) chk (.*);

	always #6 clk = ~clk;

	// Hard limit on the length of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Output stalls in random bursts, none once the run has gone calm.
	initial begin
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// Durations are mostly short so that patterns move along, sometimes anything.
	function automatic logic [15:0] random_duration();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1, 2: return 16'($urandom_range(4, 20));
			default: return 16'($urandom_range(0, 3));
		endcase
	endfunction

	// Offers one beat, possibly after a gap, and waits until it is taken.
	task automatic send_beat(input tpp_pkg::tpp_action_t act, input logic [4:0] idx,
			input logic [15:0] lev, input logic [15:0] dur);
		if (!calm && gappy && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		step_index <= idx;
		step_level <= lev;
		step_duration <= dur;
		if (act == tpp_pkg::ACT_WRITE) begin
			table_filled[idx] = 1'b1;
		end
		beats_sent++;
		calm = (beats_sent >= ITEM_TARGET - CALM_ITEMS);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// A beat whose unused fields carry random bits.
	task automatic send_plain(input tpp_pkg::tpp_action_t act);
		send_beat(act, 5'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Writes one table entry with random content.
	task automatic write_random_step(input logic [4:0] idx);
		send_beat(tpp_pkg::ACT_WRITE, idx, 16'($urandom), random_duration());
	endtask

	// Starts the pattern, first filling any entry it could reach unwritten.
	task automatic start_pattern();
		int unsigned used;
		used = (cur_step_count > 32) ? 32 : cur_step_count;
		for (int unsigned i = 0; i < used; i++) begin
			if (!table_filled[i]) begin
				write_random_step(5'(i));
			end
		end
		send_plain(tpp_pkg::ACT_START);
	endtask

	// Lets every beat in flight come out of the player.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Writes both registers on back-to-back cycles.
	task automatic set_registers(input logic [5:0] sc, input logic [7:0] pc);
		cfg_write <= 1'b1;
		cfg_index <= tpp_pkg::REG_STEP_COUNT;
		cfg_data <= {2'b00, sc};
		@(posedge clk);
		cfg_index <= tpp_pkg::REG_PLAY_COUNT;
		cfg_data <= pc;
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_step_count = sc;
	endtask

	// Stimulus: directed cases, then random phases, then the verdict.
	initial begin : stimulus
		int          phase;
		int          phase_beats;
		logic [5:0]  sc;
		logic [7:0]  pc;
		int unsigned pick;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: a single step played once. Stop and tick while idle first.
		send_beat(tpp_pkg::ACT_STOP, 5'd31, 16'hFFFF, 16'hFFFF);
		send_beat(tpp_pkg::ACT_TICK, 5'd0, 16'h0000, 16'h0000);
		send_beat(tpp_pkg::ACT_WRITE, 5'd0, 16'hFFFF, 16'h0000);
		send_beat(tpp_pkg::ACT_WRITE, 5'd1, 16'h0000, 16'd2);
		send_beat(tpp_pkg::ACT_WRITE, 5'd2, 16'h8001, 16'd1);
		send_beat(tpp_pkg::ACT_WRITE, 5'd31, 16'hFFFF, 16'hFFFF);
		send_plain(tpp_pkg::ACT_START);
		send_plain(tpp_pkg::ACT_TICK);
		send_plain(tpp_pkg::ACT_TICK);

		// A zero step count makes a start do nothing.
		wait_idle();
		set_registers(6'd0, 8'd0);
		send_plain(tpp_pkg::ACT_START);
		send_plain(tpp_pkg::ACT_TICK);

		// Three steps played twice, then restarts, a write while running and a stop.
		wait_idle();
		set_registers(6'd3, 8'd2);
		send_plain(tpp_pkg::ACT_START);
		repeat (8) send_plain(tpp_pkg::ACT_TICK);
		send_plain(tpp_pkg::ACT_START);
		send_beat(tpp_pkg::ACT_WRITE, 5'd1, 16'h1234, 16'h0000);
		send_plain(tpp_pkg::ACT_START);
		send_plain(tpp_pkg::ACT_TICK);
		send_plain(tpp_pkg::ACT_STOP);

		// Random phases, the first few at the register extremes.
		phase = 0;
		while (beats_sent < ITEM_TARGET) begin
			wait_idle();
			case (phase)
				0: begin sc = 6'd63; pc = 8'h80; end
				1: begin sc = 6'd32; pc = 8'd127; end
				2: begin sc = 6'd33; pc = 8'hFF; end
				default: begin
					pick = $urandom_range(0, 19);
					if (pick < 13) begin
						sc = 6'($urandom_range(1, 4));
					end else if (pick < 16) begin
						sc = 6'($urandom_range(5, 32));
					end else if (pick < 18) begin
						sc = 6'($urandom_range(33, 63));
					end else begin
						sc = 6'd0;
					end
					pick = $urandom_range(0, 19);
					if (pick < 8) begin
						pc = 8'($urandom_range(1, 3));
					end else if (pick < 11) begin
						pc = 8'd0;
					end else if (pick < 15) begin
						pc = 8'hFF;
					end else if (pick < 17) begin
						pc = 8'($urandom_range(128, 254));
					end else if (pick < 18) begin
						pc = 8'd127;
					end else begin
						pc = 8'($urandom_range(4, 126));
					end
				end
			endcase
			set_registers(sc, pc);
			gappy = ($urandom_range(0, 3) != 0);
			phase_beats = beats_sent + $urandom_range(30, 120);
			start_pattern();
			while (beats_sent < phase_beats && beats_sent < ITEM_TARGET) begin
				pick = $urandom_range(0, 99);
				if (pick < 76) begin
					send_plain(tpp_pkg::ACT_TICK);
				end else if (pick < 86) begin
					write_random_step(5'($urandom));
				end else if (pick < 94) begin
					start_pattern();
				end else begin
					send_plain(tpp_pkg::ACT_STOP);
				end
			end
			phase++;
		end

		// Drain and decide.
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
